@@ sv/bgl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bgl_pkg;

   localparam int MV_W   = 13;
   localparam int PCT_W  = 7;
   localparam int MODE_W = 2;
   localparam int SUM_W  = 15;
   localparam int CNT_W  = 2;
   localparam int LED_W  = 8;

   localparam int CURVE_POINTS   = 12;
   localparam int DETECT_SAMPLES = 3;

   // LiPo discharge curve, highest point first
   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700,
      13'd3650, 13'd3600, 13'd3550, 13'd3500, 13'd3400, 13'd3300
   };
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
      7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
   };

   // widest divisor and numerator over the segments that interpolate
   function automatic int seg_max_den();
      int m;
      int d;
      m = 1;
      for (int i = 0; i < CURVE_POINTS - 1; i++) begin
         if (CURVE_MV[i] > CURVE_MV[i+1] && CURVE_PCT[i] >= CURVE_PCT[i+1]) begin
            d = int'(CURVE_MV[i]) - int'(CURVE_MV[i+1]);
            if (d > m) m = d;
         end
      end
      return m;
   endfunction

   function automatic int seg_max_num();
      int m;
      int d;
      m = 1;
      for (int i = 0; i < CURVE_POINTS - 1; i++) begin
         if (CURVE_MV[i] > CURVE_MV[i+1] && CURVE_PCT[i] >= CURVE_PCT[i+1]) begin
            d = (int'(CURVE_MV[i]) - int'(CURVE_MV[i+1]))
              * (int'(CURVE_PCT[i]) - int'(CURVE_PCT[i+1]));
            if (d > m) m = d;
         end
      end
      return m;
   endfunction

   localparam int MAX_DEN = seg_max_den();
   localparam int MAX_NUM = seg_max_num();
   localparam int DEN_W   = $clog2(MAX_DEN + 1);
   localparam int NUM_W   = $clog2(MAX_NUM + 1);
   localparam int STEP_W  = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   // average window compared as a sum: floor(sum/N) in [LOW, HIGH]
   localparam int DETECT_LOW_MV  = 2800;
   localparam int DETECT_HIGH_MV = 4500;
   localparam int SUM_LOW  = DETECT_LOW_MV * DETECT_SAMPLES;
   localparam int SUM_HIGH = DETECT_HIGH_MV * DETECT_SAMPLES + DETECT_SAMPLES - 1;

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   localparam logic [LED_W-1:0] LED_OFF   = 8'd0;
   localparam logic [LED_W-1:0] LED_ON    = 8'd50;
   localparam logic [LED_W-1:0] LED_BLINK = 8'd80;

   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FORCED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_DETECT  = 1'b1;

   localparam int DATA_W   = 32;
   localparam int NUM_REGS = 6;
   localparam int ADDR_W   = $clog2(4 * NUM_REGS);
   localparam int RIDX_W   = ADDR_W - 2;

   localparam logic [RIDX_W-1:0] REG_PRESENCE_MODE = RIDX_W'(0);
   localparam logic [RIDX_W-1:0] REG_CLAMP_MIN     = RIDX_W'(1);
   localparam logic [RIDX_W-1:0] REG_CLAMP_MAX     = RIDX_W'(2);
   localparam logic [RIDX_W-1:0] REG_GREEN_ABOVE   = RIDX_W'(3);
   localparam logic [RIDX_W-1:0] REG_YELLOW_ABOVE  = RIDX_W'(4);
   localparam logic [RIDX_W-1:0] REG_CRITICAL      = RIDX_W'(5);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      BAND_GREEN,
      BAND_YELLOW,
      BAND_RED,
      BAND_CRIT
   } band_type;

   typedef struct packed {
      logic [MODE_W-1:0] presence_mode;
      logic [MV_W-1:0]   clamp_min_mv;
      logic [MV_W-1:0]   clamp_max_mv;
      logic [PCT_W-1:0]  green_above_pct;
      logic [PCT_W-1:0]  yellow_above_pct;
      logic [PCT_W-1:0]  blink_at_pct;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

   typedef struct packed {
      logic             present;
      logic             detect_done;
      logic [MV_W-1:0]  voltage_mv;
      logic [PCT_W-1:0] percent;
      logic [LED_W-1:0] led_red;
      logic [LED_W-1:0] led_green;
      logic [LED_W-1:0] led_blue;
   } result_type;

   function automatic logic is_present(input logic [MODE_W-1:0] mode, input logic flag);
      logic p;
      case (mode)
         MODE_OFF:    p = 1'b0;
         MODE_FORCED: p = 1'b1;
         default:     p = flag;
      endcase
      return p;
   endfunction

   function automatic band_type led_band(input logic [PCT_W-1:0] pct, input cfg_type cfg);
      band_type b;
      if (pct > cfg.green_above_pct)       b = BAND_GREEN;
      else if (pct > cfg.yellow_above_pct) b = BAND_YELLOW;
      else if (pct > cfg.blink_at_pct)     b = BAND_RED;
      else                                 b = BAND_CRIT;
      return b;
   endfunction

endpackage

`default_nettype wire

@@ sv/bgl_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bgl_req_if;
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [bgl_pkg::MV_W-1:0] sample_mv;

   modport source (output valid, output operation, output sample_mv, input ready);
   modport sink   (input valid, input operation, input sample_mv, output ready);
endinterface

`default_nettype wire

@@ sv/bgl_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bgl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      present;
   logic                      detect_done;
   logic [bgl_pkg::MV_W-1:0]  voltage_mv;
   logic [bgl_pkg::PCT_W-1:0] percent;
   logic [bgl_pkg::LED_W-1:0] led_red;
   logic [bgl_pkg::LED_W-1:0] led_green;
   logic [bgl_pkg::LED_W-1:0] led_blue;

   modport source (output valid, output present, output detect_done, output voltage_mv,
                   output percent, output led_red, output led_green, output led_blue,
                   input ready);
   modport sink   (input valid, input present, input detect_done, input voltage_mv,
                   input percent, input led_red, input led_green, input led_blue,
                   output ready);
endinterface

`default_nettype wire

@@ sv/bgl_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgl_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bgl_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [bgl_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [bgl_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output bgl_pkg::cfg_type             cfg
);
   import bgl_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic [RIDX_W-1:0] ridx;
   logic              wr_en;

   assign ridx       = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (ridx)
            REG_PRESENCE_MODE: cfg_in.presence_mode    = csr_pwdata[MODE_W-1:0];
            REG_CLAMP_MIN:     cfg_in.clamp_min_mv     = csr_pwdata[MV_W-1:0];
            REG_CLAMP_MAX:     cfg_in.clamp_max_mv     = csr_pwdata[MV_W-1:0];
            REG_GREEN_ABOVE:   cfg_in.green_above_pct  = csr_pwdata[PCT_W-1:0];
            REG_YELLOW_ABOVE:  cfg_in.yellow_above_pct = csr_pwdata[PCT_W-1:0];
            REG_CRITICAL:      cfg_in.blink_at_pct     = csr_pwdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_PRESENCE_MODE: csr_prdata = DATA_W'(cfg_ff.presence_mode);
         REG_CLAMP_MIN:     csr_prdata = DATA_W'(cfg_ff.clamp_min_mv);
         REG_CLAMP_MAX:     csr_prdata = DATA_W'(cfg_ff.clamp_max_mv);
         REG_GREEN_ABOVE:   csr_prdata = DATA_W'(cfg_ff.green_above_pct);
         REG_YELLOW_ABOVE:  csr_prdata = DATA_W'(cfg_ff.yellow_above_pct);
         REG_CRITICAL:      csr_prdata = DATA_W'(cfg_ff.blink_at_pct);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.presence_mode    <= MODE_AUTO;
         cfg_ff.clamp_min_mv     <= 13'd3300;
         cfg_ff.clamp_max_mv     <= 13'd4200;
         cfg_ff.green_above_pct  <= 7'd60;
         cfg_ff.yellow_above_pct <= 7'd25;
         cfg_ff.blink_at_pct     <= 7'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/bgl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per step
module bgl_div (
   input  logic                       clock,
   input  logic                       load,
   input  logic                       step,
   input  logic [bgl_pkg::NUM_W-1:0]  num,
   input  logic [bgl_pkg::DEN_W-1:0]  den,
   output logic [bgl_pkg::NUM_W-1:0]  quo
);
   import bgl_pkg::*;

   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_dif;
   logic             fits;

   assign quo = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_dif = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      // remainder stays below the divisor, so DEN_W bits hold it
      rem_in  = fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_in  = (quo_ff << 1) | NUM_W'(fits);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/bgl_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgl_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  bgl_pkg::cmd_type           cmd,
   output bgl_pkg::status_type        status,
   input  bgl_pkg::cfg_type           cfg,
   input  logic                       req_operation,
   input  logic [bgl_pkg::MV_W-1:0]   req_sample_mv,
   output bgl_pkg::result_type        result
);
   import bgl_pkg::*;

   localparam int LAST = CURVE_POINTS - 1;

   // per-item working registers
   logic             op_ff;
   logic [MV_W-1:0]  mv_ff;
   logic [MV_W-1:0]  v_ff;
   logic [PCT_W-1:0] base_ff;
   logic             need_ff;
   logic [MV_W-1:0]  clip;
   logic [MV_W-1:0]  v_in;

   // gauge state
   logic             flag_ff, flag_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_add;
   logic             blink_ff, blink_in;
   logic [MV_W-1:0]  held_v_ff, held_v_in;
   logic [PCT_W-1:0] held_pct_ff, held_pct_in;
   logic             done_ff, done_in;

   result_type       result_ff, result_in;

   // segment lookup
   logic [MV_W-1:0]        hi, lo;
   logic [PCT_W-1:0]       ph, pl;
   logic                   found;
   logic                   seg_div;
   logic [PCT_W-1:0]       base_in;
   logic [MV_W-1:0]        dmv;
   logic [PCT_W-1:0]       dpct;
   logic [MV_W+PCT_W-1:0]  prod;
   logic [NUM_W-1:0]       num;
   logic [DEN_W-1:0]       den;
   logic [NUM_W-1:0]       quo;
   logic [PCT_W-1:0]       pct_new;
   logic                   pres;
   band_type               band;

   bgl_div u_div (
      .clock (clock),
      .load  (cmd.eval),
      .step  (cmd.div_step),
      .num   (num),
      .den   (den),
      .quo   (quo)
   );

   // clamp: limit to max first, then raise to min
   always_comb begin
      clip = (req_sample_mv > cfg.clamp_max_mv) ? cfg.clamp_max_mv : req_sample_mv;
      v_in = (clip < cfg.clamp_min_mv) ? cfg.clamp_min_mv : clip;
   end

   always_comb begin
      hi    = CURVE_MV[LAST-1];
      lo    = CURVE_MV[LAST];
      ph    = CURVE_PCT[LAST-1];
      pl    = CURVE_PCT[LAST];
      found = 1'b0;
      for (int i = 0; i < CURVE_POINTS - 1; i++) begin
         if (!found && v_ff >= CURVE_MV[i+1]) begin
            hi    = CURVE_MV[i];
            lo    = CURVE_MV[i+1];
            ph    = CURVE_PCT[i];
            pl    = CURVE_PCT[i+1];
            found = 1'b1;
         end
      end
      seg_div = 1'b0;
      if (v_ff >= CURVE_MV[0]) begin
         base_in = PCT_FULL;
      end else if (v_ff <= CURVE_MV[LAST]) begin
         base_in = PCT_EMPTY;
      end else if (hi == lo || ph < pl) begin
         base_in = pl;
      end else begin
         base_in = pl;
         seg_div = 1'b1;
      end
      dmv  = v_ff - lo;
      dpct = ph - pl;
      prod = dmv * dpct;
      num  = NUM_W'(prod);
      den  = DEN_W'(hi - lo);
      status.need_div = (op_ff == OP_MEASURE) && is_present(cfg.presence_mode, flag_ff)
                        && seg_div;
   end

   // state update for the item
   always_comb begin
      pct_new     = base_ff + (need_ff ? PCT_W'(quo) : PCT_EMPTY);
      sum_add     = sum_ff + SUM_W'(mv_ff);
      cnt_add     = cnt_ff + 1'b1;
      flag_in     = flag_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      blink_in    = blink_ff;
      held_v_in   = held_v_ff;
      held_pct_in = held_pct_ff;
      done_in     = 1'b0;
      if (op_ff == OP_DETECT) begin
         if (cfg.presence_mode != MODE_OFF && cfg.presence_mode != MODE_FORCED) begin
            if (cnt_add >= CNT_W'(DETECT_SAMPLES)) begin
               flag_in = (sum_add >= SUM_W'(SUM_LOW)) && (sum_add <= SUM_W'(SUM_HIGH));
               sum_in  = '0;
               cnt_in  = '0;
               done_in = 1'b1;
            end else begin
               sum_in = sum_add;
               cnt_in = cnt_add;
            end
         end
      end else if (is_present(cfg.presence_mode, flag_ff)) begin
         held_v_in   = v_ff;
         held_pct_in = pct_new;
         if (led_band(pct_new, cfg) == BAND_CRIT) blink_in = ~blink_ff;
      end
   end

   // result from the committed state
   always_comb begin
      pres = is_present(cfg.presence_mode, flag_ff);
      band = led_band(held_pct_ff, cfg);
      result_in.present     = pres;
      result_in.detect_done = done_ff;
      result_in.voltage_mv  = pres ? held_v_ff : '0;
      result_in.percent     = pres ? held_pct_ff : PCT_EMPTY;
      result_in.led_red     = LED_OFF;
      result_in.led_green   = LED_OFF;
      result_in.led_blue    = LED_OFF;
      if (pres) begin
         case (band)
            BAND_GREEN:  result_in.led_green = LED_ON;
            BAND_YELLOW: begin
               result_in.led_red   = LED_ON;
               result_in.led_green = LED_ON;
            end
            BAND_RED:    result_in.led_red = LED_ON;
            default:     result_in.led_red = blink_ff ? LED_BLINK : LED_OFF;
         endcase
      end
   end

   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         mv_ff <= req_sample_mv;
         v_ff  <= v_in;
      end
      if (cmd.eval) begin
         base_ff <= base_in;
         need_ff <= status.need_div;
      end
      if (cmd.emit) result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         blink_ff    <= 1'b0;
         held_v_ff   <= '0;
         held_pct_ff <= PCT_FULL;
         done_ff     <= 1'b0;
      end else if (cmd.commit) begin
         flag_ff     <= flag_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         blink_ff    <= blink_in;
         held_v_ff   <= held_v_in;
         held_pct_ff <= held_pct_in;
         done_ff     <= done_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/bgl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bgl_pkg::status_type   status,
   output bgl_pkg::cmd_type      cmd
);
   import bgl_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            step_in  = '0;
            state_in = status.need_div ? ST_DIV : ST_COMMIT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) state_in = ST_COMMIT;
            else step_in = step_ff + 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // load the output register once the previous beat has left
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/battery_gauge_led_indicator.sv @@
// Flow: an accepted input beat is captured, evaluated, committed and then loaded into
// the result register; a measure sample of a present battery that falls between two
// curve points also runs a 10-bit shift-subtract divide, one quotient bit per cycle,
// before the commit. One item in flight: the next input beat is taken the cycle after
// the result register loads, and the output register lets that result wait for the sink.
// Synchronous active-high reset sets gauge state, no clearing pass; item registers keep theirs.
`timescale 1ns / 1ps
`default_nettype none

module battery_gauge_led_indicator (
   input  logic                         clock,
   input  logic                         reset,
   bgl_req_if.sink                      req_ch,
   bgl_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bgl_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [bgl_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [bgl_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import bgl_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   result_type result;
   logic       req_ready;
   logic       rsp_valid;

   bgl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgl_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .req_operation (req_ch.operation),
      .req_sample_mv (req_ch.sample_mv),
      .result        (result)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.present     = result.present;
   assign rsp_ch.detect_done = result.detect_done;
   assign rsp_ch.voltage_mv  = result.voltage_mv;
   assign rsp_ch.percent     = result.percent;
   assign rsp_ch.led_red     = result.led_red;
   assign rsp_ch.led_green   = result.led_green;
   assign rsp_ch.led_blue    = result.led_blue;

endmodule

`default_nettype wire

@@ sv/bgl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        present,
   input logic [bgl_pkg::MV_W-1:0]    voltage_mv,
   input logic [bgl_pkg::PCT_W-1:0]   percent,
   input logic [bgl_pkg::LED_W-1:0]   led_red,
   input logic [bgl_pkg::LED_W-1:0]   led_green,
   input logic [bgl_pkg::LED_W-1:0]   led_blue
);
   import bgl_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(percent) && $stable(voltage_mv) && $stable(led_red))
      else $error("result beat changed while stalled");

   // one item in flight: no new beat right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_absent_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !present |->
         voltage_mv == '0 && percent == '0 && led_red == '0 && led_green == '0)
      else $error("absent battery shows a reading or a lit LED");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> percent <= PCT_FULL && led_blue == '0)
      else $error("percent above full scale or blue LED lit");

endmodule

bind battery_gauge_led_indicator bgl_checker u_bgl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .present    (rsp_ch.present),
   .voltage_mv (rsp_ch.voltage_mv),
   .percent    (rsp_ch.percent),
   .led_red    (rsp_ch.led_red),
   .led_green  (rsp_ch.led_green),
   .led_blue   (rsp_ch.led_blue)
);

`default_nettype wire
